@@ src/isaac_pkg.sv @@
package isaac_pkg;

    localparam int POOL_LOG2_DEF = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c13;

    // action codes of an input item
    localparam logic [1:0] ACT_SEED     = 2'd0;
    localparam logic [1:0] ACT_DRAW     = 2'd1;
    localparam logic [1:0] ACT_DRAW_MOD = 2'd2;
    localparam logic [1:0] ACT_NONE     = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] seed_word;
        logic [63:0] bound;
    } t_req;

    typedef struct packed {
        logic [63:0] value;
        logic        error;
    } t_rsp;

    typedef enum logic [2:0] {
        CMD_SEED,
        CMD_DRAW,
        CMD_DRAW_MOD,
        CMD_ZERO_BOUND,
        CMD_NOP
    } t_cmd;

    // seed word or bound, depending on the command
    typedef struct packed {
        t_cmd        cmd;
        logic [63:0] word;
    } t_cmd_entry;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEED_ADD,
        ST_SEED_MIX,
        ST_SEED_WR,
        ST_GEN_START,
        ST_G1,
        ST_G2,
        ST_G3,
        ST_G4,
        ST_G5,
        ST_DRAW_RD,
        ST_DRAW_DATA,
        ST_DIV,
        ST_OUT
    } t_core_state;

endpackage

@@ src/isaac_ram.sv @@
module isaac_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/isaac_div.sv @@
module isaac_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_rem
);

    localparam int STEPS = 64;
    localparam int CW    = $clog2(STEPS + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [63:0]   r_rem, n_rem;
    logic [63:0]   r_num, n_num;
    logic [63:0]   r_den, n_den;
    logic [64:0]   trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_num <= n_num;
        r_den <= n_den;
    end

    // restoring step, one quotient bit per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_num  = r_num;
        n_den  = r_den;
        trial  = {r_rem, r_num[63]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_num  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                trial = trial - {1'b0, r_den};
            end
            n_rem = trial[63:0];
            n_num = {r_num[62:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ src/isaac_front.sv @@
module isaac_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  isaac_pkg::t_req       i_req,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output isaac_pkg::t_cmd_entry o_cmd
);

    localparam int PW = $clog2(isaac_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(isaac_pkg::QUEUE_DEPTH + 1);

    isaac_pkg::t_cmd_entry r_q [isaac_pkg::QUEUE_DEPTH];
    logic [PW-1:0]         r_wp, r_rp;
    logic [CW-1:0]         r_cnt;
    isaac_pkg::t_cmd_entry entry;
    logic                  do_push, do_pop;

    // classify the item on entry
    always_comb begin
        entry.word = i_req.seed_word;
        case (i_req.action)
            isaac_pkg::ACT_SEED: begin
                entry.cmd = isaac_pkg::CMD_SEED;
            end
            isaac_pkg::ACT_DRAW: begin
                entry.cmd = isaac_pkg::CMD_DRAW;
            end
            isaac_pkg::ACT_DRAW_MOD: begin
                entry.word = i_req.bound;
                entry.cmd  = (i_req.bound == '0) ? isaac_pkg::CMD_ZERO_BOUND
                                                 : isaac_pkg::CMD_DRAW_MOD;
            end
            default: begin
                entry.cmd = isaac_pkg::CMD_NOP;
            end
        endcase
    end

    assign o_full      = (r_cnt == CW'(isaac_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign do_push     = i_push && !o_full;
    assign do_pop      = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= PW'(r_wp + 1'b1);
            end
            if (do_pop) begin
                r_rp <= PW'(r_rp + 1'b1);
            end
            r_cnt <= CW'(r_cnt + CW'(do_push) - CW'(do_pop));
        end
        if (do_push) begin
            r_q[r_wp] <= entry;
        end
    end

endmodule

@@ src/isaac_core.sv @@
module isaac_core #(
    parameter int POOL_LOG2 = isaac_pkg::POOL_LOG2_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  isaac_pkg::t_cmd_entry i_cmd,
    output logic                  o_empty,
    input  logic                  i_pop,
    output isaac_pkg::t_rsp       o_rsp
);

    localparam int N   = 1 << POOL_LOG2;
    localparam int AW  = POOL_LOG2;
    localparam int WLW = POOL_LOG2 + 1;
    localparam int BW  = POOL_LOG2 - 3;
    localparam logic [WLW-1:0] WL_FULL = WLW'(N);

    isaac_pkg::t_core_state r_state, n_state;
    isaac_pkg::t_cmd_entry  r_cmd, n_cmd;
    logic [AW-1:0]  r_idx, n_idx;
    logic [BW-1:0]  r_blk, n_blk;
    logic [3:0]     r_cnt, n_cnt;
    logic           r_pass, n_pass;
    logic [63:0]    r_lane [8];
    logic [63:0]    n_lane [8];
    logic [63:0]    upd [8];
    logic [63:0]    r_a, n_a, r_b, n_b, r_rc, n_rc;
    logic [63:0]    r_x, n_x, r_y, n_y;
    logic [WLW-1:0] r_wl, n_wl, wl_dec;
    logic [63:0]    r_val, n_val;
    logic           r_err, n_err;
    logic           r_out_valid, n_out_valid;
    isaac_pkg::t_rsp r_out, n_out;

    logic           pool_we, res_we;
    logic [AW-1:0]  pool_waddr, pool_raddr, res_raddr;
    logic [63:0]    pool_wdata, res_wdata, pool_rd, res_rd;
    logic           div_start, div_done;
    logic [63:0]    div_rem;
    logic [2:0]     k_add;
    logic [63:0]    addend, y_sum;

    function automatic logic [63:0] gen_mix(input logic [63:0] a, input logic [1:0] sel);
        logic [63:0] m;
        case (sel)
            2'd0:    m = ~(a ^ (a << 21));
            2'd1:    m = a ^ (a >> 5);
            2'd2:    m = a ^ (a << 12);
            default: m = a ^ (a >> 33);
        endcase
        return m;
    endfunction

    function automatic logic [63:0] row_shift(input logic [63:0] v, input logic [2:0] row);
        logic [63:0] s;
        case (row)
            3'd0:    s = v >> 9;
            3'd1:    s = v << 9;
            3'd2:    s = v >> 23;
            3'd3:    s = v << 15;
            3'd4:    s = v >> 14;
            3'd5:    s = v << 20;
            3'd6:    s = v >> 17;
            default: s = v << 14;
        endcase
        return s;
    endfunction

    isaac_ram #(.WIDTH(64), .DEPTH(N)) u_pool (
        .i_clk   (i_clk),
        .i_we    (pool_we),
        .i_waddr (pool_waddr),
        .i_wdata (pool_wdata),
        .i_raddr (pool_raddr),
        .o_rdata (pool_rd)
    );

    isaac_ram #(.WIDTH(64), .DEPTH(N)) u_result (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (r_idx),
        .i_wdata (res_wdata),
        .i_raddr (res_raddr),
        .o_rdata (res_rd)
    );

    isaac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (res_rd),
        .i_den   (r_cmd.word),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= isaac_pkg::ST_CLEAR;
            r_idx       <= '0;
            r_a         <= '0;
            r_b         <= '0;
            r_rc        <= '0;
            r_wl        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_a         <= n_a;
            r_b         <= n_b;
            r_rc        <= n_rc;
            r_wl        <= n_wl;
            r_out_valid <= n_out_valid;
        end
        r_cmd  <= n_cmd;
        r_blk  <= n_blk;
        r_cnt  <= n_cnt;
        r_pass <= n_pass;
        r_lane <= n_lane;
        r_x    <= n_x;
        r_y    <= n_y;
        r_val  <= n_val;
        r_err  <= n_err;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_blk       = r_blk;
        n_cnt       = r_cnt;
        n_pass      = r_pass;
        n_lane      = r_lane;
        n_a         = r_a;
        n_b         = r_b;
        n_rc        = r_rc;
        n_x         = r_x;
        n_y         = r_y;
        n_wl        = r_wl;
        n_val       = r_val;
        n_err       = r_err;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        o_cmd_ready = 1'b0;
        pool_we     = 1'b0;
        pool_waddr  = r_idx;
        pool_wdata  = '0;
        pool_raddr  = r_idx;
        res_we      = 1'b0;
        res_wdata   = '0;
        wl_dec      = WLW'(r_wl - 1'b1);
        res_raddr   = wl_dec[AW-1:0];
        div_start   = 1'b0;
        k_add       = 3'(r_cnt - 1'b1);
        addend      = '0;
        y_sum       = pool_rd + r_a + r_b;
        upd         = r_lane;
        upd[0]      = r_lane[0] - r_lane[4];
        upd[5]      = r_lane[5] ^ row_shift(r_lane[7], r_cnt[2:0]);
        upd[7]      = r_lane[7] + upd[0];

        case (r_state)
            isaac_pkg::ST_CLEAR: begin
                pool_we = 1'b1;
                n_idx   = AW'(r_idx + 1'b1);
                if (&r_idx) begin
                    n_state = isaac_pkg::ST_IDLE;
                end
            end
            isaac_pkg::ST_IDLE: begin
                o_cmd_ready = i_cmd_valid;
                n_cmd       = i_cmd;
                if (i_cmd_valid) begin
                    case (i_cmd.cmd)
                        isaac_pkg::CMD_SEED: begin
                            for (int k = 0; k < 8; k++) begin
                                n_lane[k] = isaac_pkg::GOLDEN;
                            end
                            n_a     = '0;
                            n_b     = '0;
                            n_rc    = '0;
                            n_blk   = '0;
                            n_cnt   = '0;
                            n_pass  = 1'b0;
                            n_state = isaac_pkg::ST_SEED_ADD;
                        end
                        isaac_pkg::CMD_DRAW, isaac_pkg::CMD_DRAW_MOD: begin
                            n_state = (r_wl == '0) ? isaac_pkg::ST_GEN_START
                                                   : isaac_pkg::ST_DRAW_RD;
                        end
                        isaac_pkg::CMD_ZERO_BOUND: begin
                            n_val   = '0;
                            n_err   = 1'b1;
                            n_state = isaac_pkg::ST_OUT;
                        end
                        default: begin
                            n_val   = '0;
                            n_err   = 1'b0;
                            n_state = isaac_pkg::ST_OUT;
                        end
                    endcase
                end
            end
            isaac_pkg::ST_SEED_ADD: begin
                pool_raddr = {r_blk, r_cnt[2:0]};
                if (r_pass) begin
                    addend = pool_rd;
                end else if (r_blk == '0 && k_add == 3'd0) begin
                    addend = r_cmd.word;
                end
                if (r_cnt != 4'd0) begin
                    n_lane[k_add] = r_lane[k_add] + addend;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 4'd8) begin
                    n_cnt   = '0;
                    n_state = isaac_pkg::ST_SEED_MIX;
                end
            end
            isaac_pkg::ST_SEED_MIX: begin
                // one row of the mix, lanes rotated so the row always sits at lane 0
                for (int k = 0; k < 8; k++) begin
                    n_lane[k] = upd[3'(k + 1)];
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 4'd7) begin
                    n_cnt   = '0;
                    n_state = isaac_pkg::ST_SEED_WR;
                end
            end
            isaac_pkg::ST_SEED_WR: begin
                pool_we    = 1'b1;
                pool_waddr = {r_blk, r_cnt[2:0]};
                pool_wdata = r_lane[r_cnt[2:0]];
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == 4'd7) begin
                    n_cnt   = '0;
                    n_blk   = BW'(r_blk + 1'b1);
                    n_state = isaac_pkg::ST_SEED_ADD;
                    if (&r_blk) begin
                        n_pass = 1'b1;
                        if (r_pass) begin
                            n_state = isaac_pkg::ST_GEN_START;
                        end
                    end
                end
            end
            isaac_pkg::ST_GEN_START: begin
                n_rc       = r_rc + 1'b1;
                n_b        = r_b + r_rc + 1'b1;
                n_idx      = '0;
                pool_raddr = '0;
                n_state    = isaac_pkg::ST_G1;
            end
            isaac_pkg::ST_G1: begin
                n_x        = pool_rd;
                pool_raddr = {~r_idx[AW-1], r_idx[AW-2:0]};
                n_state    = isaac_pkg::ST_G2;
            end
            isaac_pkg::ST_G2: begin
                n_a        = gen_mix(r_a, r_idx[1:0]) + pool_rd;
                pool_raddr = r_x[3 +: AW];
                n_state    = isaac_pkg::ST_G3;
            end
            isaac_pkg::ST_G3: begin
                pool_we    = 1'b1;
                pool_wdata = y_sum;
                n_y        = y_sum;
                n_state    = isaac_pkg::ST_G4;
            end
            isaac_pkg::ST_G4: begin
                pool_raddr = r_y[AW+3 +: AW];
                n_state    = isaac_pkg::ST_G5;
            end
            isaac_pkg::ST_G5: begin
                n_b        = pool_rd + r_x;
                res_we     = 1'b1;
                res_wdata  = n_b;
                n_idx      = AW'(r_idx + 1'b1);
                pool_raddr = n_idx;
                n_state    = isaac_pkg::ST_G1;
                if (&r_idx) begin
                    n_wl = WL_FULL;
                    if (r_cmd.cmd == isaac_pkg::CMD_SEED) begin
                        n_val   = r_cmd.word;
                        n_err   = 1'b0;
                        n_state = isaac_pkg::ST_OUT;
                    end else begin
                        n_state = isaac_pkg::ST_DRAW_RD;
                    end
                end
            end
            isaac_pkg::ST_DRAW_RD: begin
                n_wl    = wl_dec;
                n_state = isaac_pkg::ST_DRAW_DATA;
            end
            isaac_pkg::ST_DRAW_DATA: begin
                if (r_cmd.cmd == isaac_pkg::CMD_DRAW_MOD) begin
                    div_start = 1'b1;
                    n_state   = isaac_pkg::ST_DIV;
                end else begin
                    n_val   = res_rd;
                    n_err   = 1'b0;
                    n_state = isaac_pkg::ST_OUT;
                end
            end
            isaac_pkg::ST_DIV: begin
                if (div_done) begin
                    n_val   = div_rem;
                    n_err   = 1'b0;
                    n_state = isaac_pkg::ST_OUT;
                end
            end
            isaac_pkg::ST_OUT: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid = 1'b1;
                    n_out.value = r_val;
                    n_out.error = r_err;
                    n_state     = isaac_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = isaac_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_empty = !r_out_valid;
    assign o_rsp   = r_out;

    a_wl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wl <= WL_FULL)
        else $error("words left beyond pool size");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == isaac_pkg::ST_DIV)
        else $error("remainder finished outside the modulo step");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid && $stable(r_out))
        else $error("waiting result changed before it was taken");

    a_gen_write_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == isaac_pkg::ST_G3 |=> r_state == isaac_pkg::ST_G4 && r_y == $past(y_sum))
        else $error("pool word not settled before its second lookup");

endmodule

@@ src/isaac64_random_generator.sv @@
// channel  | direction | handshake                  | payload
// request  | in        | push / full                | i_req  (action, seed_word, bound)
// result   | out       | empty / pop                | o_rsp  (value, error)
//
// after reset the pool is swept to zero, one word a cycle;
// items can queue in the meantime but none is carried out until it ends
// a draw from the buffer reads the result RAM; a modulo draw also runs the
// bit-serial remainder unit
// a regeneration takes each pool word through steps G1 to G5, one pool read at a time
// a seed adds, mixes and writes back each 8-word block over two passes, then one regeneration
// a two-entry queue in front keeps accepting items until full while the back end works or
// while a result waits to be popped
module isaac64_random_generator #(
    parameter int POOL_LOG2 = isaac_pkg::POOL_LOG2_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  isaac_pkg::t_req i_req,
    output logic            empty,
    input  logic            pop,
    output isaac_pkg::t_rsp o_rsp
);

    // classified item between the front queue and the back end
    isaac_pkg::t_cmd_entry cmd;
    logic                  cmd_valid;
    logic                  cmd_ready;

    // front: classify each item and queue it
    isaac_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // back: seeding, generation rounds, draws, remainder and the result register
    isaac_core #(.POOL_LOG2(POOL_LOG2)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_rsp       (o_rsp)
    );

endmodule

@@ test/tb_isaac64_random_generator.sv @@
module tb_isaac64_random_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOG2      = 8;
    localparam int PSIZE     = 1 << LOG2;
    localparam int N_RANDOM  = 1700;
    // slowest item: a full regeneration plus a modulo draw,
    // or a seed (two mix passes and a regeneration), plus the longest stalls
    localparam int IDLE_LIMIT = 40000;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    isaac_pkg::t_req i_req;
    logic empty;
    logic pop;
    isaac_pkg::t_rsp o_rsp;

    isaac64_random_generator #(.POOL_LOG2(LOG2)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .empty   (empty),
        .pop     (pop),
        .o_rsp   (o_rsp)
    );

    // clock, 20 ns period
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // predictor state
    logic [63:0] gen_pool [PSIZE];
    logic [63:0] gen_words [PSIZE];
    logic [63:0] gen_a;
    logic [63:0] gen_b;
    logic [63:0] gen_round;
    int          gen_left;

    isaac_pkg::t_req pending_items [$];
    isaac_pkg::t_rsp expected_rsp [$];

    int  mismatches;
    bit  done_sending;
    int  idle_cycles;

    function automatic logic [63:0] pool_pick(logic [63:0] x);
        return gen_pool[(x >> 3) & (PSIZE - 1)];
    endfunction

    // one generation round over the whole pool
    task automatic regen_pool();
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] m;
        a = gen_a;
        gen_round = gen_round + 64'd1;
        b = gen_b + gen_round;
        for (int i = 0; i < PSIZE; i++) begin
            x = gen_pool[i];
            case (i & 3)
                0: m = ~(a ^ (a << 21));
                1: m = a ^ (a >> 5);
                2: m = a ^ (a << 12);
                default: m = a ^ (a >> 33);
            endcase
            a = m + gen_pool[(i + PSIZE / 2) & (PSIZE - 1)];
            y = pool_pick(x) + a + b;
            gen_pool[i] = y;
            b = pool_pick(y >> LOG2) + x;
            gen_words[i] = b;
        end
        gen_a = a;
        gen_b = b;
    endtask

    task automatic golden_mix(inout logic [63:0] s [8]);
        s[0] -= s[4]; s[5] ^= s[7] >> 9;  s[7] += s[0];
        s[1] -= s[5]; s[6] ^= s[0] << 9;  s[0] += s[1];
        s[2] -= s[6]; s[7] ^= s[1] >> 23; s[1] += s[2];
        s[3] -= s[7]; s[0] ^= s[2] << 15; s[2] += s[3];
        s[4] -= s[0]; s[1] ^= s[3] >> 14; s[3] += s[4];
        s[5] -= s[1]; s[2] ^= s[4] << 20; s[4] += s[5];
        s[6] -= s[2]; s[3] ^= s[5] >> 17; s[5] += s[6];
        s[7] -= s[3]; s[4] ^= s[6] << 14; s[6] += s[7];
    endtask

    task automatic seed_pool(logic [63:0] seed);
        logic [63:0] s [8];
        for (int i = 0; i < PSIZE; i++) begin
            gen_pool[i] = '0;
            gen_words[i] = '0;
        end
        gen_a = '0;
        gen_b = '0;
        gen_round = '0;
        gen_words[0] = seed;
        for (int k = 0; k < 8; k++) s[k] = isaac_pkg::GOLDEN;
        // first pass folds in the seed words, second the pool itself
        for (int p = 0; p < 2; p++) begin
            for (int i = 0; i < PSIZE; i += 8) begin
                for (int k = 0; k < 8; k++)
                    s[k] += (p == 0) ? gen_words[i + k] : gen_pool[i + k];
                golden_mix(s);
                for (int k = 0; k < 8; k++) gen_pool[i + k] = s[k];
            end
        end
        regen_pool();
        gen_left = PSIZE;
    endtask

    task automatic next_word(output logic [63:0] w);
        if (gen_left == 0) begin
            regen_pool();
            gen_left = PSIZE;
        end
        gen_left--;
        w = gen_words[gen_left & (PSIZE - 1)];
    endtask

    task automatic predict_rsp(isaac_pkg::t_req it);
        isaac_pkg::t_rsp r;
        logic [63:0] w;
        r = '0;
        case (it.action)
            isaac_pkg::ACT_SEED: begin
                seed_pool(it.seed_word);
                r.value = it.seed_word;
            end
            isaac_pkg::ACT_DRAW: begin
                next_word(w);
                r.value = w;
            end
            isaac_pkg::ACT_DRAW_MOD: begin
                if (it.bound == 64'd0) begin
                    r.error = 1'b1;
                end else begin
                    next_word(w);
                    r.value = w % it.bound;
                end
            end
            default: ;
        endcase
        expected_rsp.push_back(r);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic isaac_pkg::t_req make_item(logic [1:0] act, logic [63:0] sw,
                                                  logic [63:0] bd);
        isaac_pkg::t_req it;
        it.action = act;
        it.seed_word = sw;
        it.bound = bd;
        return it;
    endfunction

    // random bound: often small, sometimes wide or a power of two, rarely zero
    function automatic logic [63:0] rand_bound();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 64'd0;
        if (sel < 5) return 64'($urandom_range(1, 1000));
        if (sel < 8) return rand64();
        return 64'd1 << $urandom_range(0, 63);
    endfunction

    // stimulus: directed, then random
    initial begin
        // draw straight after reset regenerates from the all-zero state
        pending_items.push_back(make_item(isaac_pkg::ACT_DRAW, '1, '1));
        pending_items.push_back(make_item(isaac_pkg::ACT_DRAW_MOD, '0, 64'd0));
        pending_items.push_back(make_item(isaac_pkg::ACT_DRAW_MOD, '1, '1));
        // unused action returns zero and leaves the generator state alone
        pending_items.push_back(make_item(isaac_pkg::ACT_NONE, '1, '1));
        pending_items.push_back(make_item(isaac_pkg::ACT_SEED, 64'd0, '1));
        pending_items.push_back(make_item(isaac_pkg::ACT_DRAW, '0, '0));
        pending_items.push_back(make_item(isaac_pkg::ACT_DRAW_MOD, '0, 64'd1));
        pending_items.push_back(make_item(isaac_pkg::ACT_SEED, '1, '0));
        pending_items.push_back(make_item(isaac_pkg::ACT_DRAW_MOD, '0, '1));
        pending_items.push_back(make_item(isaac_pkg::ACT_DRAW_MOD, '0,
                                          64'h8000000000000000));
        pending_items.push_back(make_item(isaac_pkg::ACT_DRAW_MOD, '0, 64'd0));
        pending_items.push_back(make_item(isaac_pkg::ACT_SEED, isaac_pkg::GOLDEN, 64'd7));
        pending_items.push_back(make_item(isaac_pkg::ACT_DRAW_MOD, '1, 64'd3));
        pending_items.push_back(make_item(isaac_pkg::ACT_NONE, '0, '0));
        for (int i = 0; i < N_RANDOM; i++) begin
            int sel;
            sel = $urandom_range(0, 99);
            if (sel < 2)
                pending_items.push_back(make_item(isaac_pkg::ACT_SEED, rand64(), rand64()));
            else if (sel < 4)
                pending_items.push_back(make_item(isaac_pkg::ACT_NONE, rand64(), rand64()));
            else if (sel < 50)
                pending_items.push_back(make_item(isaac_pkg::ACT_DRAW, rand64(), rand64()));
            else
                pending_items.push_back(make_item(isaac_pkg::ACT_DRAW_MOD, rand64(),
                                                  rand_bound()));
        end
    end

    // reset, asserted at the start and then released
    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sender
    int send_gap;
    int sent_count;
    initial begin
        push = 1'b0;
        i_req = '0;
        send_gap = 0;
        sent_count = 0;
        done_sending = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                // item taken at this edge
                predict_rsp(i_req);
                sent_count++;
                void'(pending_items.pop_front());
                // bursts with no gaps every few hundred items
                send_gap = ((sent_count / 200) % 3 == 1) ? 0 : $urandom_range(0, 7);
            end
            if (push && full) begin
                // hold the offered item
            end else if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (pending_items.size() > 0) begin
                push <= 1'b1;
                i_req <= pending_items[0];
            end else begin
                push <= 1'b0;
                done_sending = 1'b1;
            end
        end
    end

    // receiver, with one long hold-off so the input queue backs up
    int pop_gap;
    int hold_off;
    bit held_once;
    initial begin
        pop = 1'b0;
        pop_gap = 0;
        hold_off = 0;
        held_once = 1'b0;
        mismatches = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_rsp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result value=%h error=%b",
                                 o_rsp.value, o_rsp.error);
                end else begin
                    isaac_pkg::t_rsp exp_r;
                    exp_r = expected_rsp.pop_front();
                    if (exp_r.value !== o_rsp.value || exp_r.error !== o_rsp.error) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected value=%h error=%b,",
                                      " got value=%h error=%b"},
                                     exp_r.value, exp_r.error, o_rsp.value, o_rsp.error);
                    end
                end
                pop_gap = ((sent_count / 200) % 3 == 2) ? 0 : $urandom_range(0, 7);
                if (!held_once && sent_count > 40) begin
                    held_once = 1'b1;
                    hold_off = 3000;
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog and end of run
    initial begin
        idle_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (done_sending && pending_items.size() == 0 && expected_rsp.size() == 0)
                break;
        end
        // let any stray result show up
        repeat (200) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
